### rtl/core/fir_circ_pkg.sv
`timescale 1ns / 1ps

package fir_circ_pkg;

  localparam int TAPS           = 64;
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_BITS      = 16;
  localparam int COEF_IDX_BITS  = 6;
  localparam int TAP_CNT_BITS   = 7;
  localparam int STEP_BITS      = $clog2(TAPS);
  localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
  // One guard bit beyond the worst-case growth of the sum.
  localparam int ACC_BITS       = PROD_BITS + $clog2(TAPS) + 1;
  localparam int IN_TDATA_BITS  = 40;
  localparam int OUT_TDATA_BITS = 16;

  // Command carried on tuser of the input stream.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic tap_en;
  } mac_ctrl_t;

endpackage

### rtl/core/fir_circ_cell.sv
`timescale 1ns / 1ps

module fir_circ_cell (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  fir_circ_pkg::cell_ctrl_t                ctrl_i,
  input  logic                                    coef_we_i,
  input  logic signed [fir_circ_pkg::COEF_BITS-1:0]   coef_value_i,
  input  logic signed [fir_circ_pkg::SAMPLE_BITS-1:0] x_shift_i,
  input  logic signed [fir_circ_pkg::SAMPLE_BITS-1:0] x_rot_i,
  input  logic signed [fir_circ_pkg::COEF_BITS-1:0]   c_rot_i,
  output logic signed [fir_circ_pkg::SAMPLE_BITS-1:0] x_o,
  output logic signed [fir_circ_pkg::COEF_BITS-1:0]   c_o
);
  import fir_circ_pkg::*;

  logic signed [SAMPLE_BITS-1:0] x_d, x_q;
  logic signed [COEF_BITS-1:0]   c_d, c_q;

  always_comb begin
    x_d = x_q;
    c_d = c_q;
    if (ctrl_i.shift) begin
      x_d = x_shift_i;
    end else if (ctrl_i.rotate) begin
      x_d = x_rot_i;
      c_d = c_rot_i;
    end
    if (coef_we_i) begin
      c_d = coef_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      c_q <= '0;
    end else begin
      x_q <= x_d;
      c_q <= c_d;
    end
  end

  assign x_o = x_q;
  assign c_o = c_q;

endmodule

### rtl/core/fir_circ_mac.sv
`timescale 1ns / 1ps

module fir_circ_mac (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  fir_circ_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [fir_circ_pkg::SAMPLE_BITS-1:0] x_i,
  input  logic signed [fir_circ_pkg::COEF_BITS-1:0]   c_i,
  output logic signed [fir_circ_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic                                    saturated_o
);
  import fir_circ_pkg::*;

  localparam logic signed [ACC_BITS-1:0] RND_HALF = ACC_BITS'(2 ** (COEF_BITS - 2));
  localparam logic signed [ACC_BITS-1:0] Y_MAX    = ACC_BITS'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [ACC_BITS-1:0] Y_MIN    = -Y_MAX - ACC_BITS'(1);

  logic signed [PROD_BITS-1:0] prod_d, prod_q;
  logic                        prod_v_d, prod_v_q;
  logic signed [ACC_BITS-1:0]  acc_d, acc_q;
  logic signed [ACC_BITS-1:0]  rnd, y;

  assign prod_d   = x_i * c_i;
  assign prod_v_d = ctrl_i.capture & ctrl_i.tap_en;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_v_q) begin
      acc_d = acc_q + ACC_BITS'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= prod_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  // Round half up at the coefficient fraction point, then clip to the sample range.
  assign rnd = acc_q + RND_HALF;
  assign y   = rnd >>> (COEF_BITS - 1);

  always_comb begin
    saturated_o  = 1'b0;
    sample_out_o = y[SAMPLE_BITS-1:0];
    if (y > Y_MAX) begin
      saturated_o  = 1'b1;
      sample_out_o = Y_MAX[SAMPLE_BITS-1:0];
    end else if (y < Y_MIN) begin
      saturated_o  = 1'b1;
      sample_out_o = Y_MIN[SAMPLE_BITS-1:0];
    end
  end

endmodule

### rtl/core/fir_filter_circular.sv
`timescale 1ns / 1ps
// A sample transfer is answered on the output stream after the run, drain and output states.
// Input is taken only in idle; a new sample waits until the last one is worked through.
// The run state does one multiply-accumulate per tap, fed by rotating the cell row past cell 0.
// A waiting result holds the block only once the next sum is finished.
// Reset (asynchronous, active low) zeroes every cell, the tap count and the output valid.

module fir_filter_circular (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [fir_circ_pkg::TAP_CNT_BITS-1:0]      cfg_data_i,    // tap_count
  input  logic                                       s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  // sample_in [15:0], coef_index [21:16], coef_value [37:22], zero [39:38]
  input  logic [fir_circ_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata_i,
  input  logic                                       s_axis_tuser_i, // command
  output logic                                       m_axis_tvalid_o,
  input  logic                                       m_axis_tready_i,
  output logic [fir_circ_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata_o, // sample_out [15:0]
  output logic                                       m_axis_tuser_o  // saturated
);
  import fir_circ_pkg::*;

  state_e state_q, state_d;
  logic [STEP_BITS-1:0]    step_q, step_d;
  logic [TAP_CNT_BITS-1:0] tap_count_q;

  logic                          in_xfer, out_xfer, out_load, last_step;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [COEF_IDX_BITS-1:0]      coef_index;
  logic signed [COEF_BITS-1:0]   coef_value;
  logic                          coef_we;

  cell_ctrl_t cell_ctrl;
  mac_ctrl_t  mac_ctrl;

  logic signed [SAMPLE_BITS-1:0] x_cell [TAPS];
  logic signed [COEF_BITS-1:0]   c_cell [TAPS];

  logic signed [SAMPLE_BITS-1:0] mac_sample;
  logic                          mac_sat;
  logic                          out_valid_q;
  logic [OUT_TDATA_BITS-1:0]     out_data_q;
  logic                          out_sat_q;

  assign sample_in  = s_axis_tdata_i[15:0];
  assign coef_index = s_axis_tdata_i[21:16];
  assign coef_value = s_axis_tdata_i[37:22];

  assign in_xfer   = s_axis_tvalid_i & s_axis_tready_o;
  assign out_xfer  = m_axis_tvalid_o & m_axis_tready_i;
  assign last_step = (step_q == STEP_BITS'(TAPS - 1));
  assign coef_we   = in_xfer & (s_axis_tuser_i == CMD_COEF);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tap_count_q <= cfg_data_i;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (in_xfer && s_axis_tuser_i == CMD_SAMPLE) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        step_d = step_q + STEP_BITS'(1);
        if (last_step) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_axis_tready_o  = 1'b0;
    cell_ctrl        = '0;
    mac_ctrl         = '0;
    out_load         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        cell_ctrl.shift = in_xfer & (s_axis_tuser_i == CMD_SAMPLE);
        mac_ctrl.clear  = 1'b1;
      end
      ST_RUN: begin
        // Cell 0 holds tap step_q; a full turn brings the row back to its place.
        cell_ctrl.rotate = 1'b1;
        mac_ctrl.capture = 1'b1;
        mac_ctrl.tap_en  = ({1'b0, step_q} < tap_count_q);
      end
      ST_DRAIN: begin
      end
      ST_OUT: begin
        out_load = ~out_valid_q | m_axis_tready_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= mac_sample;
      out_sat_q  <= mac_sat;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_sat_q;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    localparam int NEXT = (k + 1) % TAPS;
    logic signed [SAMPLE_BITS-1:0] x_shift;

    if (k == 0) begin : g_head
      assign x_shift = sample_in;
    end else begin : g_body
      assign x_shift = x_cell[k-1];
    end

    fir_circ_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .coef_we_i    (coef_we && (coef_index == COEF_IDX_BITS'(k))),
      .coef_value_i (coef_value),
      .x_shift_i    (x_shift),
      .x_rot_i      (x_cell[NEXT]),
      .c_rot_i      (c_cell[NEXT]),
      .x_o          (x_cell[k]),
      .c_o          (c_cell[k])
    );
  end

  fir_circ_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (mac_ctrl),
    .x_i          (x_cell[0]),
    .c_i          (c_cell[0]),
    .sample_out_o (mac_sample),
    .saturated_o  (mac_sat)
  );

  a_sample_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tuser_i == CMD_SAMPLE) |=> (state_q == ST_RUN && step_q == '0))
    else $error("sample transfer did not start a full pass at tap zero");

  a_drain_after_full_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> ($past(state_q) == ST_RUN && $past(step_q) == STEP_BITS'(TAPS - 1)))
    else $error("accumulation ended before the cell row completed a turn");

  a_result_only_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> ($past(state_q) == ST_OUT))
    else $error("result raised outside the output state");

  a_no_input_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN || state_q == ST_DRAIN) |-> (!cell_ctrl.shift && !coef_we))
    else $error("cell row modified during accumulation");

endmodule
